@@ hw/rtl/prb_pkg.sv @@
// ----------------------------------------------------------------------------
// prb_pkg
// shared widths, codes and defaults of the packet ring buffer
// ----------------------------------------------------------------------------
package prb_pkg;

    localparam int SIZE_W        = 13;   // ring size and byte counts
    localparam int LEN_W         = 13;
    localparam int OFF_W         = 12;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 3;
    localparam int BYTE_W        = 8;

    localparam int RING_BYTES_DEF = 4096;
    localparam int RESET_SIZE     = 4096;
    localparam int MIN_SIZE       = 16;
    localparam int TRAILER_BYTES  = 8;
    localparam int TRAILER_W      = 32;  // width of the index word in the trailer

    // default working width of the index arithmetic
    localparam int WORK_W_DEF     = 15;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_BEGIN = 3'd0,
        CMD_WRITE_BYTE  = 3'd1,
        CMD_READ_BEGIN  = 3'd2,
        CMD_PEEK_BEGIN  = 3'd3,
        CMD_READ_NEXT   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 3'd0,
        STS_NO_SPACE   = 3'd1,
        STS_SHORT_DATA = 3'd2,
        STS_ZERO_LEN   = 3'd3,
        STS_NO_TXN     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_PEEK  = 2'd3
    } mode_t;

endpackage

@@ hw/rtl/prb_ram.sv @@
// ----------------------------------------------------------------------------
// prb_ram
// byte store of the ring: one write port, one read port, registered read
// ----------------------------------------------------------------------------
module prb_ram #(
    parameter int DEPTH = prb_pkg::RING_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [prb_pkg::BYTE_W-1:0]    wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [prb_pkg::BYTE_W-1:0]    rd_data
);

    logic [prb_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [prb_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/prb_mod_unit.sv @@
// ----------------------------------------------------------------------------
// prb_mod_unit
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module prb_mod_unit #(
    parameter int WIDTH = prb_pkg::WORK_W_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [WIDTH-1:0]            dividend,
    input  logic [prb_pkg::SIZE_W-1:0]  divisor,
    output logic                        done,
    output logic [WIDTH-1:0]            remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] trial;

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[WIDTH-2:0], dvd_reg[WIDTH-1]};
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the shifted-out top bit is zero
            rem_next = (trial >= WIDTH'(divisor)) ? trial - WIDTH'(divisor) : trial;
            dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/packet_ring_buffer_with_trailer_top.sv @@
// ----------------------------------------------------------------------------
// packet_ring_buffer_with_trailer_top
// packet byte ring with committed read/write indices and an 8-byte trailer
// ----------------------------------------------------------------------------
// A byte ring of ring_size bytes (13-bit register, clamped to 16..RING_BYTES
// and at most 8191; writing it clears both indices and drops any open
// transaction) holds packets between a committed read and a committed write
// index. Every request gives exactly one result. Requests land in a one-deep
// input register, so a new request is taken while a result still waits on the
// m_ side. Begin commands, write_byte and peek answer through the result
// register; read_next answers after the registered memory read, in S_RDATA;
// the last write_byte and a zero-length write_begin answer once the 8 trailer
// bytes have gone through the single memory write port one per cycle in
// S_TRAIL; a successful read_begin waits in S_MOD for the remainder unit (15
// bit steps at the default size) to work out (read + offset) mod size.
// avail_read and avail_write are taken straight from the committed indices;
// bar a size write they cannot move while a result is held, since the next
// request is only processed once the output register is free. No clearing
// pass is needed: unwritten bytes are never read by a legal request sequence.
// ----------------------------------------------------------------------------
module packet_ring_buffer_with_trailer_top #(
    parameter int RING_BYTES = prb_pkg::RING_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [prb_pkg::SIZE_W-1:0]     cfg_wr_data,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [prb_pkg::CMD_W-1:0]      s_cmd,
    input  logic [prb_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic [prb_pkg::LEN_W-1:0]      s_length,
    input  logic [prb_pkg::OFF_W-1:0]      s_offset,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [prb_pkg::STATUS_W-1:0]   m_status,
    output logic [prb_pkg::BYTE_W-1:0]     m_data_out,
    output logic                           m_last,
    output logic [prb_pkg::SIZE_W-1:0]     m_avail_read,
    output logic [prb_pkg::SIZE_W-1:0]     m_avail_write
);

    localparam int AW     = $clog2(RING_BYTES);
    // working width: room for index + offset and for the remainder shifts
    localparam int WORK_W = ((AW > prb_pkg::SIZE_W) ? AW : prb_pkg::SIZE_W) + 2;
    localparam int TCNT_W = $clog2(prb_pkg::TRAILER_BYTES);
    localparam int SIZE_CAP = (RING_BYTES > 8191) ? 8191 : RING_BYTES;
    localparam int SIZE_RST = (RING_BYTES < prb_pkg::RESET_SIZE) ?
                              RING_BYTES : prb_pkg::RESET_SIZE;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TRAIL = 4'b0010,
        S_MOD   = 4'b0100,
        S_RDATA = 4'b1000
    } fsm_t;

    // input holding register
    logic                           in_valid_reg, in_valid_next;
    logic [prb_pkg::CMD_W-1:0]      in_cmd_reg;
    logic [prb_pkg::BYTE_W-1:0]     in_data_reg;
    logic [prb_pkg::LEN_W-1:0]      in_len_reg;
    logic [prb_pkg::OFF_W-1:0]      in_off_reg;

    // ring state
    logic [prb_pkg::SIZE_W-1:0]     size_reg, size_next;
    logic [AW-1:0]                  rd_idx_reg, rd_idx_next;
    logic [AW-1:0]                  wr_idx_reg, wr_idx_next;
    logic [AW-1:0]                  wp_reg, wp_next;
    logic [prb_pkg::LEN_W-1:0]      left_reg, left_next;
    prb_pkg::mode_t                 mode_reg, mode_next;
    fsm_t                           state_reg, state_next;
    logic [TCNT_W-1:0]              tcnt_reg, tcnt_next;
    logic                           last_pend_reg, last_pend_next;

    // result register
    logic                           m_valid_reg, m_valid_next;
    prb_pkg::status_t               status_reg, status_next;
    logic [prb_pkg::BYTE_W-1:0]     data_out_reg, data_out_next;
    logic                           last_reg, last_next;

    // datapath
    logic                           out_free;
    logic                           go;
    logic [WORK_W-1:0]              w_ext, r_ext, sz_ext;
    logic [WORK_W-1:0]              free_bytes, read_bytes, need_bytes;
    logic [prb_pkg::TRAILER_W-1:0]  trailer_word;
    logic [prb_pkg::BYTE_W-1:0]     trailer_byte;
    logic [prb_pkg::SIZE_W-1:0]     cfg_size;
    prb_pkg::cmd_t                  cmd;

    // memory and remainder unit ports
    logic                           ram_we, ram_re;
    logic [AW-1:0]                  ram_waddr, ram_raddr;
    logic [prb_pkg::BYTE_W-1:0]     ram_wdata, ram_rdata;
    logic                           mod_start, mod_done;
    logic [WORK_W-1:0]              mod_rem;

    // step one byte forward around the ring
    function automatic logic [AW-1:0] adv1(input logic [AW-1:0] p,
                                           input logic [WORK_W-1:0] sz);
        logic [WORK_W-1:0] t;
        t = WORK_W'(p) + WORK_W'(1);
        return (t == sz) ? '0 : t[AW-1:0];
    endfunction

    // skip the trailer: size is at least 16, so one subtract is enough
    function automatic logic [AW-1:0] adv_trailer(input logic [AW-1:0] p,
                                                  input logic [WORK_W-1:0] sz);
        logic [WORK_W-1:0] t;
        t = WORK_W'(p) + WORK_W'(prb_pkg::TRAILER_BYTES);
        if (t >= sz) begin
            t = t - sz;
        end
        return t[AW-1:0];
    endfunction

    assign s_ready  = !in_valid_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign go       = in_valid_reg && out_free && (state_reg == S_IDLE);
    assign cmd      = prb_pkg::cmd_t'(in_cmd_reg);

    // space accounting from the committed indices
    assign w_ext      = WORK_W'(wr_idx_reg);
    assign r_ext      = WORK_W'(rd_idx_reg);
    assign sz_ext     = WORK_W'(size_reg);
    assign free_bytes = (w_ext >= r_ext) ? sz_ext - (w_ext - r_ext) : r_ext - w_ext;
    assign read_bytes = sz_ext - free_bytes;
    assign need_bytes = WORK_W'(in_len_reg) + WORK_W'(prb_pkg::TRAILER_BYTES);

    // trailer: four zero bytes, then the old write index little endian
    assign trailer_word = prb_pkg::TRAILER_W'(wr_idx_reg);
    always_comb begin
        trailer_byte = '0;
        if (tcnt_reg[TCNT_W-1]) begin
            trailer_byte = trailer_word[{tcnt_reg[TCNT_W-2:0], 3'b000} +: prb_pkg::BYTE_W];
        end
    end

    // clamp of the size register
    always_comb begin
        cfg_size = cfg_wr_data;
        if (cfg_wr_data < prb_pkg::SIZE_W'(prb_pkg::MIN_SIZE)) begin
            cfg_size = prb_pkg::SIZE_W'(prb_pkg::MIN_SIZE);
        end else if (cfg_wr_data > prb_pkg::SIZE_W'(SIZE_CAP)) begin
            cfg_size = prb_pkg::SIZE_W'(SIZE_CAP);
        end
    end

    // main sequencer
    always_comb begin
        in_valid_next  = in_valid_reg;
        size_next      = size_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        wp_next        = wp_reg;
        left_next      = left_reg;
        mode_next      = mode_reg;
        state_next     = state_reg;
        tcnt_next      = tcnt_reg;
        last_pend_next = last_pend_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        status_next    = status_reg;
        data_out_next  = data_out_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = in_data_reg;
        ram_re         = 1'b0;
        ram_raddr      = wp_reg;
        mod_start      = 1'b0;

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (go) begin
                    in_valid_next = 1'b0;
                    // default result: ok, no data, not last
                    m_valid_next  = 1'b1;
                    status_next   = prb_pkg::STS_OK;
                    data_out_next = '0;
                    last_next     = 1'b0;
                    unique case (cmd)
                        prb_pkg::CMD_WRITE_BEGIN: begin
                            mode_next = prb_pkg::MODE_IDLE;
                            if (free_bytes <= need_bytes) begin
                                status_next = prb_pkg::STS_NO_SPACE;
                            end else begin
                                wp_next   = wr_idx_reg;
                                left_next = in_len_reg;
                                mode_next = prb_pkg::MODE_WRITE;
                                if (in_len_reg == '0) begin
                                    // empty packet: trailer only
                                    m_valid_next = 1'b0;
                                    tcnt_next    = '0;
                                    state_next   = S_TRAIL;
                                end
                            end
                        end
                        prb_pkg::CMD_WRITE_BYTE: begin
                            if (mode_reg != prb_pkg::MODE_WRITE) begin
                                status_next = prb_pkg::STS_NO_TXN;
                            end else begin
                                ram_we    = 1'b1;
                                wp_next   = adv1(wp_reg, sz_ext);
                                left_next = left_reg - prb_pkg::LEN_W'(1);
                                if (left_reg == prb_pkg::LEN_W'(1)) begin
                                    m_valid_next = 1'b0;
                                    tcnt_next    = '0;
                                    state_next   = S_TRAIL;
                                end
                            end
                        end
                        prb_pkg::CMD_READ_BEGIN, prb_pkg::CMD_PEEK_BEGIN: begin
                            mode_next = prb_pkg::MODE_IDLE;
                            if (cmd == prb_pkg::CMD_READ_BEGIN && in_len_reg == '0) begin
                                status_next = prb_pkg::STS_ZERO_LEN;
                            end else if (read_bytes < WORK_W'(in_len_reg)) begin
                                status_next = prb_pkg::STS_SHORT_DATA;
                            end else if (in_len_reg != '0) begin
                                left_next = in_len_reg;
                                if (cmd == prb_pkg::CMD_PEEK_BEGIN) begin
                                    wp_next   = rd_idx_reg;
                                    mode_next = prb_pkg::MODE_PEEK;
                                end else begin
                                    // start index needs a true remainder
                                    m_valid_next = 1'b0;
                                    mod_start    = 1'b1;
                                    state_next   = S_MOD;
                                end
                            end
                        end
                        prb_pkg::CMD_READ_NEXT: begin
                            if (mode_reg != prb_pkg::MODE_READ &&
                                mode_reg != prb_pkg::MODE_PEEK) begin
                                status_next = prb_pkg::STS_NO_TXN;
                            end else begin
                                m_valid_next   = 1'b0;
                                ram_re         = 1'b1;
                                wp_next        = adv1(wp_reg, sz_ext);
                                left_next      = left_reg - prb_pkg::LEN_W'(1);
                                last_pend_next = (left_reg == prb_pkg::LEN_W'(1));
                                if (left_reg == prb_pkg::LEN_W'(1)) begin
                                    if (mode_reg == prb_pkg::MODE_READ) begin
                                        rd_idx_next = adv_trailer(adv1(wp_reg, sz_ext),
                                                                  sz_ext);
                                    end
                                    mode_next = prb_pkg::MODE_IDLE;
                                end
                                state_next = S_RDATA;
                            end
                        end
                        default: begin
                            status_next = prb_pkg::STS_NO_TXN;
                        end
                    endcase
                end
            end
            S_TRAIL: begin
                ram_we    = 1'b1;
                ram_wdata = trailer_byte;
                wp_next   = adv1(wp_reg, sz_ext);
                tcnt_next = tcnt_reg + TCNT_W'(1);
                if (tcnt_reg == TCNT_W'(prb_pkg::TRAILER_BYTES - 1)) begin
                    // commit the packet
                    wr_idx_next   = adv1(wp_reg, sz_ext);
                    mode_next     = prb_pkg::MODE_IDLE;
                    m_valid_next  = 1'b1;
                    status_next   = prb_pkg::STS_OK;
                    data_out_next = '0;
                    last_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    wp_next       = mod_rem[AW-1:0];
                    mode_next     = prb_pkg::MODE_READ;
                    m_valid_next  = 1'b1;
                    status_next   = prb_pkg::STS_OK;
                    data_out_next = '0;
                    last_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            S_RDATA: begin
                m_valid_next  = 1'b1;
                status_next   = prb_pkg::STS_OK;
                data_out_next = ram_rdata;
                last_next     = last_pend_reg;
                state_next    = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // resize: to be written only while idle; the block itself does not enforce this
        if (cfg_wr_en) begin
            size_next   = cfg_size;
            rd_idx_next = '0;
            wr_idx_next = '0;
            wp_next     = '0;
            left_next   = '0;
            mode_next   = prb_pkg::MODE_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            size_reg      <= prb_pkg::SIZE_W'(SIZE_RST);
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            wp_reg        <= '0;
            left_reg      <= '0;
            mode_reg      <= prb_pkg::MODE_IDLE;
            state_reg     <= S_IDLE;
            tcnt_reg      <= '0;
            last_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            size_reg      <= size_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            wp_reg        <= wp_next;
            left_reg      <= left_next;
            mode_reg      <= mode_next;
            state_reg     <= state_next;
            tcnt_reg      <= tcnt_next;
            last_pend_reg <= last_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_cmd;
            in_data_reg <= s_data_byte;
            in_len_reg  <= s_length;
            in_off_reg  <= s_offset;
        end
        status_reg   <= status_next;
        data_out_reg <= data_out_next;
        last_reg     <= last_next;
    end

    prb_ram #(
        .DEPTH (RING_BYTES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // (read index + offset) mod size
    prb_mod_unit #(
        .WIDTH (WORK_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (r_ext + WORK_W'(in_off_reg)),
        .divisor   (size_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // outputs
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_data_out    = data_out_reg;
    assign m_last        = last_reg;
    assign m_avail_read  = read_bytes[prb_pkg::SIZE_W-1:0];
    assign m_avail_write = free_bytes[prb_pkg::SIZE_W-1:0];

endmodule

@@ tb/tb_packet_ring_buffer_with_trailer_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_ring_buffer_with_trailer_top
// self-checking bench for the packet byte ring with trailer
// ----------------------------------------------------------------------------
// Requests come from a queue that the stimulus process fills. An in-bench
// model of the ring computes the expected result of every request as it is
// queued, since the block answers each request with exactly one result and
// keeps them in order. The run walks through six phases of ring size,
// clamped values and both ends included. It begins with a short hand-built
// sequence and then generates packet writes, reads and peeks with random
// content, mixed with out-of-turn and malformed requests. Both sides back
// off at random, except during one phase that runs at full pressure.
// ----------------------------------------------------------------------------
module tb_packet_ring_buffer_with_trailer_top;
    import prb_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int PHASE_ITEMS  = 115;
    localparam int SETTLE       = 24;      // well past the slowest request
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 200;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  length;
        logic [OFF_W-1:0]  offset;
    } ring_req_t;

    typedef struct {
        status_t           status;
        logic [BYTE_W-1:0] data_out;
        logic              last;
        logic [SIZE_W-1:0] avail_read;
        logic [SIZE_W-1:0] avail_write;
    } ring_rsp_t;

    // clock, reset, dut ports
    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [SIZE_W-1:0]   cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd       = '0;
    logic [BYTE_W-1:0]   s_data_byte = '0;
    logic [LEN_W-1:0]    s_length    = '0;
    logic [OFF_W-1:0]    s_offset    = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [BYTE_W-1:0]   m_data_out;
    logic                m_last;
    logic [SIZE_W-1:0]   m_avail_read;
    logic [SIZE_W-1:0]   m_avail_write;

    // request and result bookkeeping
    ring_req_t queued_requests[$];
    ring_rsp_t predicted_results[$];
    int        packet_lengths[$];   // committed packets not yet read, oldest first
    int        n_posted     = 0;
    int        n_accepted   = 0;
    int        phase_items  = 0;
    int        errors       = 0;
    int        n_closed     = 0;
    int        cycle_count  = 0;
    int        status_seen [8];
    bit        throttle     = 1'b1;
    ring_req_t drv_req;
    ring_rsp_t mon_want;

    // ring model state
    logic [BYTE_W-1:0] ring_mem [RING_BYTES_DEF];
    bit                ring_written [RING_BYTES_DEF];
    int                ring_len;
    int                rd_idx;
    int                wr_idx;
    int                cur_ptr;
    int                bytes_to_go;
    mode_t             ring_mode;

    packet_ring_buffer_with_trailer_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_data_byte   (s_data_byte),
        .s_length      (s_length),
        .s_offset      (s_offset),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_data_out    (m_data_out),
        .m_last        (m_last),
        .m_avail_read  (m_avail_read),
        .m_avail_write (m_avail_write)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------------
    // ring model
    // ------------------------------------------------------------------------
    function automatic int ring_free();
        if (wr_idx >= rd_idx) return ring_len - (wr_idx - rd_idx);
        return rd_idx - wr_idx;
    endfunction

    // store at the work pointer and step it round the ring
    function automatic void ring_store_byte(logic [BYTE_W-1:0] v);
        ring_mem[cur_ptr]     = v;
        ring_written[cur_ptr] = 1'b1;
        cur_ptr = (cur_ptr + 1) % ring_len;
    endfunction

    // trailer: four zero bytes then the old write index, little-endian
    function automatic void ring_seal_packet();
        logic [63:0] trailer;
        trailer = 64'(wr_idx) << TRAILER_W;
        for (int i = 0; i < TRAILER_BYTES; i++) ring_store_byte(trailer[8*i +: 8]);
        wr_idx    = cur_ptr;
        ring_mode = MODE_IDLE;
    endfunction

    // a size write clamps, clears both indices and drops any open transaction
    function automatic void ring_resize(logic [SIZE_W-1:0] v);
        int n;
        n = v;
        if (n < MIN_SIZE) n = MIN_SIZE;
        if (n > RING_BYTES_DEF) n = RING_BYTES_DEF;
        ring_len    = n;
        rd_idx      = 0;
        wr_idx      = 0;
        cur_ptr     = 0;
        bytes_to_go = 0;
        ring_mode   = MODE_IDLE;
    endfunction

    function automatic ring_rsp_t ring_apply(ring_req_t r);
        ring_rsp_t o;
        int        fw;
        o.status   = STS_OK;
        o.data_out = '0;
        o.last     = 1'b0;
        case (r.cmd)
            CMD_WRITE_BEGIN: begin
                ring_mode = MODE_IDLE;
                if (ring_free() <= int'(r.length) + TRAILER_BYTES) begin
                    o.status = STS_NO_SPACE;
                end else begin
                    cur_ptr     = wr_idx;
                    bytes_to_go = r.length;
                    ring_mode   = MODE_WRITE;
                    if (r.length == 0) begin
                        ring_seal_packet();
                        o.last = 1'b1;
                    end
                end
            end
            CMD_WRITE_BYTE: begin
                if (ring_mode != MODE_WRITE) begin
                    o.status = STS_NO_TXN;
                end else begin
                    ring_store_byte(r.data_byte);
                    bytes_to_go--;
                    if (bytes_to_go == 0) begin
                        ring_seal_packet();
                        o.last = 1'b1;
                    end
                end
            end
            CMD_READ_BEGIN, CMD_PEEK_BEGIN: begin
                ring_mode = MODE_IDLE;
                if (r.cmd == CMD_READ_BEGIN && r.length == 0) begin
                    o.status = STS_ZERO_LEN;
                end else if (ring_len - ring_free() < int'(r.length)) begin
                    o.status = STS_SHORT_DATA;
                end else if (r.length != 0) begin
                    bytes_to_go = r.length;
                    if (r.cmd == CMD_READ_BEGIN) begin
                        cur_ptr   = (rd_idx + r.offset) % ring_len;
                        ring_mode = MODE_READ;
                    end else begin
                        cur_ptr   = rd_idx;
                        ring_mode = MODE_PEEK;
                    end
                end
            end
            CMD_READ_NEXT: begin
                if (ring_mode != MODE_READ && ring_mode != MODE_PEEK) begin
                    o.status = STS_NO_TXN;
                end else begin
                    o.data_out = ring_mem[cur_ptr];
                    cur_ptr    = (cur_ptr + 1) % ring_len;
                    bytes_to_go--;
                    if (bytes_to_go == 0) begin
                        o.last = 1'b1;
                        // a read skips the trailer and commits, a peek does not
                        if (ring_mode == MODE_READ) rd_idx = (cur_ptr + TRAILER_BYTES) % ring_len;
                        ring_mode = MODE_IDLE;
                    end
                end
            end
            default: begin
                o.status = STS_NO_TXN;
            end
        endcase
        fw            = ring_free();
        o.avail_write = SIZE_W'(fw);
        o.avail_read  = SIZE_W'(ring_len - fw);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus generation: every request is predicted as it is queued
    // ------------------------------------------------------------------------
    function automatic ring_rsp_t post_request(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len,
                                               logic [OFF_W-1:0] off, logic [BYTE_W-1:0] dbyte);
        ring_req_t r;
        ring_rsp_t p;
        r.cmd       = cmd;
        r.length    = len;
        r.offset    = off;
        r.data_byte = dbyte;
        p = ring_apply(r);
        queued_requests.push_back(r);
        predicted_results.push_back(p);
        n_posted++;
        phase_items++;
        return p;
    endfunction

    // one packet: mostly ones that fit, some refused right at the space limit,
    // now and then cut short so that the next begin abandons it
    function automatic void make_packet();
        int fw, len, cap, cut;
        fw = ring_free();
        if (fw < TRAILER_BYTES + 1 || $urandom_range(99) < 12) begin
            len = $urandom_range(fw > TRAILER_BYTES ? fw - TRAILER_BYTES : 0, fw + 40);
        end else if (fw <= 64 && $urandom_range(9) == 0) begin
            len = fw - TRAILER_BYTES - 1;   // largest packet that still fits
        end else begin
            cap = ($urandom_range(4) == 0) ? 200 : 20;
            if (cap > fw - TRAILER_BYTES - 1) cap = fw - TRAILER_BYTES - 1;
            len = $urandom_range(0, cap);
        end
        void'(post_request(CMD_WRITE_BEGIN, len, $urandom_range(0, (1 << OFF_W) - 1),
                           $urandom_range(0, 255)));
        if (ring_mode != MODE_WRITE) begin
            if (len == 0 && ring_free() != fw) packet_lengths.push_back(0);
            return;
        end
        cut = ($urandom_range(11) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < cut; i++)
            void'(post_request(CMD_WRITE_BYTE, $urandom_range(0, (1 << LEN_W) - 1),
                               $urandom_range(0, (1 << OFF_W) - 1), $urandom_range(0, 255)));
        if (cut == len) packet_lengths.push_back(len);
    endfunction

    // a read or peek; reads mostly take the oldest packet whole, otherwise
    // part of the readable bytes at an offset that keeps the read index
    // behind the write index once the trailer skip is added
    function automatic void make_fetch(bit peek);
        logic [CMD_W-1:0] cmd;
        int               avail, span, len, off, start, cut;
        bit               clean;
        cmd   = peek ? CMD_PEEK_BEGIN : CMD_READ_BEGIN;
        avail = ring_len - ring_free();
        if (packet_lengths.size() > 0 && packet_lengths[0] == 0) packet_lengths.delete();
        span = peek ? avail : avail - TRAILER_BYTES;
        if (span < 1) begin
            // nothing to take cleanly: ask for more than there is
            void'(post_request(cmd, avail + 1 + $urandom_range(0, 40),
                               $urandom_range(0, (1 << OFF_W) - 1), $urandom_range(0, 255)));
            return;
        end
        off = 0;
        if (!peek && packet_lengths.size() > 0 && $urandom_range(3) != 0) begin
            len = packet_lengths[0];
        end else begin
            len = $urandom_range(1, (span > 40 && $urandom_range(3) != 0) ? 40 : span);
            if (!peek && $urandom_range(3) == 0) off = $urandom_range(0, span - len);
        end
        start = peek ? rd_idx : (rd_idx + off) % ring_len;
        clean = 1'b1;
        for (int i = 0; i < len; i++) clean &= ring_written[(start + i) % ring_len];
        if (!clean) len = 0;    // never fetch a byte that was not stored
        void'(post_request(cmd, len, off, $urandom_range(0, 255)));
        if (ring_mode != MODE_READ && ring_mode != MODE_PEEK) return;
        cut = ($urandom_range(11) == 0) ? $urandom_range(0, len - 1) : len;
        for (int i = 0; i < cut; i++)
            void'(post_request(CMD_READ_NEXT, $urandom_range(0, (1 << LEN_W) - 1),
                               $urandom_range(0, (1 << OFF_W) - 1), $urandom_range(0, 255)));
        if (peek || cut < len) return;
        if (off == 0 && packet_lengths.size() > 0 && packet_lengths[0] == len)
            void'(packet_lengths.pop_front());
        else
            packet_lengths.delete();
    endfunction

    // out-of-turn, malformed and refused requests, with the remaining fields random
    function automatic void make_noise();
        int avail;
        avail = ring_len - ring_free();
        case ($urandom_range(5))
            0: void'(post_request(CMD_WRITE_BYTE, $urandom_range(0, (1 << LEN_W) - 1),
                                  $urandom_range(0, (1 << OFF_W) - 1), $urandom_range(0, 255)));
            1: void'(post_request(CMD_READ_NEXT, $urandom_range(0, (1 << LEN_W) - 1),
                                  $urandom_range(0, (1 << OFF_W) - 1), $urandom_range(0, 255)));
            2: void'(post_request($urandom_range(CMD_READ_NEXT + 1, (1 << CMD_W) - 1),
                                  $urandom_range(0, (1 << LEN_W) - 1),
                                  $urandom_range(0, (1 << OFF_W) - 1), $urandom_range(0, 255)));
            3: void'(post_request(CMD_WRITE_BEGIN,
                                  $urandom_range(ring_free(), (1 << LEN_W) - 1),
                                  $urandom_range(0, (1 << OFF_W) - 1), $urandom_range(0, 255)));
            4: void'(post_request($urandom_range(0, 1) ? CMD_READ_BEGIN : CMD_PEEK_BEGIN,
                                  $urandom_range(avail + 1, (1 << LEN_W) - 1),
                                  $urandom_range(0, (1 << OFF_W) - 1), $urandom_range(0, 255)));
            default: void'(post_request($urandom_range(0, 1) ? CMD_READ_BEGIN : CMD_PEEK_BEGIN,
                                        0, $urandom_range(0, (1 << OFF_W) - 1),
                                        $urandom_range(0, 255)));
        endcase
    endfunction

    // hand-built opening at the reset size of 4096
    function automatic void make_directed();
        void'(post_request(CMD_READ_NEXT, 0, 0, 0));                  // nothing open
        void'(post_request(CMD_WRITE_BYTE, 0, 0, 8'hFF));             // nothing open
        void'(post_request((1 << CMD_W) - 1, 0, 0, 0));               // unknown command
        void'(post_request(CMD_READ_BEGIN, 0, 0, 0));                 // zero-length read
        void'(post_request(CMD_PEEK_BEGIN, 0, 0, 0));                 // zero-length peek
        void'(post_request(CMD_READ_BEGIN, 1, 0, 0));                 // empty ring
        void'(post_request(CMD_WRITE_BEGIN, (1 << LEN_W) - 1, 0, 0)); // far too long
        void'(post_request(CMD_WRITE_BEGIN, RESET_SIZE - TRAILER_BYTES, 0, 0)); // just too long
        void'(post_request(CMD_WRITE_BEGIN, 0, 0, 0));                // trailer only, bytes 0..7
        void'(post_request(CMD_WRITE_BEGIN, 3, 0, 0));                // bytes 8..10, trailer to 18
        void'(post_request(CMD_WRITE_BYTE, 0, 0, 8'h00));
        void'(post_request(CMD_WRITE_BYTE, 0, 0, 8'hFF));
        void'(post_request(CMD_WRITE_BYTE, 0, 0, 8'hA5));
        void'(post_request(CMD_READ_BEGIN, 3, TRAILER_BYTES, 0));     // skip the empty packet
        repeat (3) void'(post_request(CMD_READ_NEXT, 0, 0, 0));
        void'(post_request(CMD_WRITE_BEGIN, 4, 0, 0));                // abandoned half way
        void'(post_request(CMD_WRITE_BYTE, 0, 0, 8'h5A));
        void'(post_request(CMD_WRITE_BYTE, 0, 0, 8'hC3));
        void'(post_request(CMD_WRITE_BEGIN, 2, 0, 0));                // restarts at the same index
        void'(post_request(CMD_WRITE_BYTE, 0, 0, 8'h01));
        void'(post_request(CMD_WRITE_BYTE, 0, 0, 8'h80));
        void'(post_request(CMD_READ_BEGIN, 2, (1 << OFF_W) - 1, 0));  // wraps to one byte back
        repeat (2) void'(post_request(CMD_READ_NEXT, 0, 0, 0));
    endfunction

    task automatic wait_drained();
        while (queued_requests.size() != 0 || n_accepted != n_posted ||
               predicted_results.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) n_accepted++;
            // a fresh request only once the previous one has gone
            if (!s_valid || s_ready) begin
                if (queued_requests.size() > 0 && !(throttle && $urandom_range(99) < 7)) begin
                    drv_req      = queued_requests.pop_front();
                    s_valid     <= 1'b1;
                    s_cmd       <= drv_req.cmd;
                    s_data_byte <= drv_req.data_byte;
                    s_length    <= drv_req.length;
                    s_offset    <= drv_req.offset;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and checker
    // ------------------------------------------------------------------------
    function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                if (predicted_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, got status %0d",
                             $time, m_status);
                end else begin
                    mon_want = predicted_results.pop_front();
                    check_field("status", mon_want.status, m_status);
                    check_field("data_out", mon_want.data_out, m_data_out);
                    check_field("last", mon_want.last, m_last);
                    check_field("avail_read", mon_want.avail_read, m_avail_read);
                    check_field("avail_write", mon_want.avail_write, m_avail_write);
                    if (!$isunknown(m_status)) status_seen[m_status]++;
                    if (m_last === 1'b1) n_closed++;
                end
            end
            m_ready <= !(throttle && $urandom_range(99) < 7);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d requests queued and %0d results outstanding",
                     $time, queued_requests.size(), predicted_results.size());
            $display("tb_packet_ring_buffer_with_trailer_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // run sequence: reset, opening sequence, then one random phase per size
    // ------------------------------------------------------------------------
    initial begin
        logic [SIZE_W-1:0] cfg_values [5];
        int                sel;
        // clamped low, clamped high, a random middle size, both exact ends
        cfg_values[0] = '0;
        cfg_values[1] = '1;
        cfg_values[2] = $urandom_range(MIN_SIZE + 1, 400);
        cfg_values[3] = MIN_SIZE;
        cfg_values[4] = RESET_SIZE;
        ring_resize(RESET_SIZE);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        make_directed();
        packet_lengths.delete();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                // resize only with the block drained and settled
                wait_drained();
                repeat (SETTLE) @(posedge aclk);
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= cfg_values[ph-1];
                @(posedge aclk);
                cfg_wr_en   <= 1'b0;
                ring_resize(cfg_values[ph-1]);
                packet_lengths.delete();
            end
            throttle    = (ph != 1);   // the first resized phase, a ring clamped to 16, runs without back-off
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                sel = $urandom_range(99);
                if (sel < 40)      make_packet();
                else if (sel < 72) make_fetch(1'b0);
                else if (sel < 84) make_fetch(1'b1);
                else               make_noise();
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        $display("covered %0d requests over 6 ring sizes, %0d transactions closed",
                 n_posted, n_closed);
        $display("results: %0d ok, %0d no space, %0d short data, %0d zero length, %0d out of turn",
                 status_seen[STS_OK], status_seen[STS_NO_SPACE], status_seen[STS_SHORT_DATA],
                 status_seen[STS_ZERO_LEN], status_seen[STS_NO_TXN]);
        if (errors == 0) begin
            $display("tb_packet_ring_buffer_with_trailer_top OK");
        end else begin
            $display("tb_packet_ring_buffer_with_trailer_top NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/prb_pkg.sv
hw/rtl/prb_ram.sv
hw/rtl/prb_mod_unit.sv
hw/rtl/packet_ring_buffer_with_trailer_top.sv
tb/tb_packet_ring_buffer_with_trailer_top.sv
